// File: rtl/mrc_pkg.sv
package mrc_pkg;

  localparam int NUM_DIMS       = 6;
  localparam int DIG_W          = 16;
  localparam int IDX_W          = 32;
  localparam int RAD_W          = DIG_W + 1;
  localparam int SEL_W          = 3;
  localparam int BITS_PER_STAGE = 4;
  localparam int STAGES_PER_DIM = IDX_W / BITS_PER_STAGE;
  localparam int NUM_STAGES     = NUM_DIMS * STAGES_PER_DIM;
  localparam int FOLD_W         = IDX_W + RAD_W + 1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ACTIVE_DIMS = 3'd0;
  localparam logic [2:0] REG_RADIX_0     = 3'd1;
  localparam logic [2:0] REG_RADIX_5     = 3'd6;

  typedef struct packed {
    logic                              req;
    logic [IDX_W-1:0]                  dq;
    logic [RAD_W-1:0]                  rem;
    logic [NUM_DIMS-1:0][DIG_W-1:0]    digit;
    logic [IDX_W-1:0]                  acc;
    logic                              ovf;
    logic [NUM_DIMS-1:0][DIG_W-1:0]    din;
  } item_t;

  typedef struct packed {
    logic             div_on;
    logic             dim_end;
    logic [SEL_W-1:0] dig_sel;
    logic [RAD_W-1:0] div_radix;
    logic             fold_on;
    logic [SEL_W-1:0] fold_sel;
    logic [RAD_W-1:0] fold_radix;
  } ctl_t;

  // a zero radix stands for 65536
  function automatic logic [RAD_W-1:0] eff_radix(input logic [DIG_W-1:0] r);
    eff_radix = (r == '0) ? {1'b1, {DIG_W{1'b0}}} : {1'b0, r};
  endfunction

endpackage

// File: rtl/mrc_stage.sv
module mrc_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  mrc_pkg::ctl_t ctl,
  input  logic          up_valid,
  output logic          up_ready,
  input  mrc_pkg::item_t up_item,
  output logic          dn_valid,
  input  logic          dn_ready,
  output mrc_pkg::item_t dn_item
);

  logic                                   valid_r;
  mrc_pkg::item_t                         item_r;
  mrc_pkg::item_t                         item_nxt;
  logic [mrc_pkg::RAD_W:0]                sh;
  logic [mrc_pkg::RAD_W-1:0]              rem;
  logic [mrc_pkg::IDX_W-1:0]              dq;
  logic [mrc_pkg::FOLD_W-1:0]             fold;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_comb begin
    item_nxt = up_item;
    rem      = up_item.rem;
    dq       = up_item.dq;
    sh       = '0;
    fold     = '0;
    if (ctl.div_on) begin
      // restoring division, a few quotient bits per stage
      for (int k = 0; k < mrc_pkg::BITS_PER_STAGE; k++) begin
        sh = {rem, dq[mrc_pkg::IDX_W-1]};
        dq = {dq[mrc_pkg::IDX_W-2:0], 1'b0};
        if (sh >= {1'b0, ctl.div_radix}) begin
          sh    = sh - {1'b0, ctl.div_radix};
          dq[0] = 1'b1;
        end
        rem = sh[mrc_pkg::RAD_W-1:0];
      end
      if (ctl.dim_end) begin
        item_nxt.digit[ctl.dig_sel] = rem[mrc_pkg::DIG_W-1:0];
        rem = '0;
      end
    end
    item_nxt.rem = rem;
    item_nxt.dq  = dq;
    if (ctl.fold_on && up_item.req) begin
      fold = mrc_pkg::FOLD_W'(up_item.acc) * mrc_pkg::FOLD_W'(ctl.fold_radix)
           + mrc_pkg::FOLD_W'(up_item.din[ctl.fold_sel]);
      if (fold[mrc_pkg::FOLD_W-1:mrc_pkg::IDX_W] != '0) item_nxt.ovf = 1'b1;
      item_nxt.acc = fold[mrc_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: rtl/mixed_radix_index_converter_unit.sv
// channel | dir | handshake            | payload
// in_     | in  | tvalid/tready        | tuser req_type, tdata flat_index + digits
// out_    | out | tvalid/tready        | tdata index_out, overflow, digits
// cfg_    | in  | apb psel/penable     | active_dims, radix_0..radix_5
// one item per cycle sustained while out_tready is high; the pipe depth is set by the divider:
//   six dimensions of 32-bit division at 4 quotient bits per stage
// the fold for composing runs in the first six stages of the same pipe
// rst_n clears valid bits and registers (active_dims 1, radices 1)
// a stall holds each full stage with no empty stage below it; empty stages still fill behind it
module mixed_radix_index_converter_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // flat_index, digit_in_0 .. digit_in_5
  input  logic         in_tuser,  // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata, // index_out, overflow, digit_out_0 .. digit_out_5, zeros
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [2:0]                                          active_dims_r;
  logic [mrc_pkg::NUM_DIMS-1:0][mrc_pkg::DIG_W-1:0]    radix_r;
  logic [2:0]                                          dims;
  logic [2:0]                                          reg_sel;
  logic                                                cfg_wr;

  logic           vld [0:mrc_pkg::NUM_STAGES];
  logic           rdy [0:mrc_pkg::NUM_STAGES];
  mrc_pkg::item_t itm [0:mrc_pkg::NUM_STAGES];

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dims_r <= 3'd1;
      for (int i = 0; i < mrc_pkg::NUM_DIMS; i++) radix_r[i] <= 16'd1;
    end else if (cfg_wr) begin
      if (reg_sel == mrc_pkg::REG_ACTIVE_DIMS) begin
        active_dims_r <= cfg_pwdata[2:0];
      end else if (reg_sel >= mrc_pkg::REG_RADIX_0 && reg_sel <= mrc_pkg::REG_RADIX_5) begin
        radix_r[reg_sel - mrc_pkg::REG_RADIX_0] <= cfg_pwdata[15:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == mrc_pkg::REG_ACTIVE_DIMS) begin
      cfg_prdata = {29'd0, active_dims_r};
    end else if (reg_sel >= mrc_pkg::REG_RADIX_0 && reg_sel <= mrc_pkg::REG_RADIX_5) begin
      cfg_prdata = {16'd0, radix_r[reg_sel - mrc_pkg::REG_RADIX_0]};
    end
  end

  assign dims = (active_dims_r > 3'(mrc_pkg::NUM_DIMS)) ? 3'(mrc_pkg::NUM_DIMS) : active_dims_r;

  // entry: a compose item divides zero so its digits come out zero
  always_comb begin
    itm[0]       = '0;
    itm[0].req   = in_tuser;
    itm[0].dq    = in_tuser ? '0 : in_tdata[31:0];
    itm[0].din   = in_tdata[127:32];
  end
  assign vld[0]    = in_tvalid;
  assign in_tready = rdy[0];

  for (genvar s = 0; s < mrc_pkg::NUM_STAGES; s++) begin : g_stage
    localparam int DIM  = mrc_pkg::NUM_DIMS - 1 - s / mrc_pkg::STAGES_PER_DIM;
    localparam int FSEL = (s < mrc_pkg::NUM_DIMS) ? s : 0;
    mrc_pkg::ctl_t ctl;
    always_comb begin
      ctl.div_on     = 3'(DIM) < dims;
      ctl.dim_end    = (s % mrc_pkg::STAGES_PER_DIM) == mrc_pkg::STAGES_PER_DIM - 1;
      ctl.dig_sel    = 3'(DIM);
      ctl.div_radix  = mrc_pkg::eff_radix(radix_r[DIM]);
      ctl.fold_on    = (s < mrc_pkg::NUM_DIMS) && (3'(FSEL) < dims);
      ctl.fold_sel   = 3'(FSEL);
      ctl.fold_radix = mrc_pkg::eff_radix(radix_r[FSEL]);
    end
    mrc_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .up_valid (vld[s]),
      .up_ready (rdy[s]),
      .up_item  (itm[s]),
      .dn_valid (vld[s+1]),
      .dn_ready (rdy[s+1]),
      .dn_item  (itm[s+1])
    );
  end

  assign out_tvalid                  = vld[mrc_pkg::NUM_STAGES];
  assign rdy[mrc_pkg::NUM_STAGES]    = out_tready;
  assign out_tdata = {7'd0, itm[mrc_pkg::NUM_STAGES].digit, itm[mrc_pkg::NUM_STAGES].ovf,
                      itm[mrc_pkg::NUM_STAGES].acc};

  a_compose_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && itm[mrc_pkg::NUM_STAGES].req |-> out_tdata[128:33] == '0)
    else $error("compose item carries nonzero digits");

  a_decompose_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !itm[mrc_pkg::NUM_STAGES].req |-> out_tdata[32:0] == '0)
    else $error("decompose item carries index or overflow");

  a_remainder_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> itm[mrc_pkg::NUM_STAGES].rem == '0)
    else $error("remainder left over at output");

  a_inactive_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && dims < 3'(mrc_pkg::NUM_DIMS) |-> out_tdata[128:113] == '0)
    else $error("inactive digit nonzero");

  a_empty_pipe_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld[1] |-> in_tready)
    else $error("input stalled with empty first stage");

endmodule
